### rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// Shared widths, register indexes and stage types of the PID speed controller.
// ----------------------------------------------------------------------------
package pms_pkg;

	localparam int GAIN_W     = 16;
	localparam int LIM_W      = 15;
	localparam int SP_W       = 16;
	localparam int MEAS_W     = 16;
	localparam int ERR_W      = 16;
	localparam int RAW_W      = 18;
	localparam int SUM_W      = 17;
	localparam int DIFF_W     = 17;
	localparam int PROD_W     = 32;
	localparam int DPROD_W    = 33;
	localparam int TOT_W      = 35;
	localparam int DRIVE_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd3;

	localparam logic [LIM_W-1:0]   INTEG_LIMIT_RST = 15'h7fff;
	localparam logic [DRIVE_W-1:0] DRIVE_MAX       = 8'd255;
	localparam logic [DRIVE_W-1:0] DRIVE_MIN       = 8'd0;
	localparam logic signed [ERR_W-1:0] ERR_MAX    = 16'sh7fff;
	localparam logic signed [ERR_W-1:0] ERR_MIN    = -16'sh8000;

	typedef struct packed {
		logic signed [GAIN_W-1:0] p_gain;
		logic signed [GAIN_W-1:0] i_gain;
		logic signed [GAIN_W-1:0] d_gain;
		logic [LIM_W-1:0]         integ_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [DIFF_W-1:0] diff;
		logic signed [ERR_W-1:0]  isum;
		logic                     clamp;
	} front_t;

	typedef struct packed {
		logic signed [PROD_W-1:0]  pterm;
		logic signed [PROD_W-1:0]  iterm;
		logic signed [DPROD_W-1:0] dterm;
	} prod_t;

endpackage

### rtl/pms_ifs.sv
// ----------------------------------------------------------------------------
// pms_ifs
// Sample and result channels of the PID speed controller.
// ----------------------------------------------------------------------------
interface pms_in_if import pms_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [SP_W-1:0]  setpoint;
	logic [MEAS_W-1:0]       measured;

	modport source(output valid, setpoint, measured, input ready);
	modport sink(input valid, setpoint, measured, output ready);
endinterface

interface pms_out_if import pms_pkg::*;;
	logic               valid;
	logic               ready;
	logic [DRIVE_W-1:0] drive;

	modport source(output valid, drive, input ready);
	modport sink(input valid, drive, output ready);
endinterface

### rtl/pms_cfg_regs.sv
// ----------------------------------------------------------------------------
// pms_cfg_regs
// Gain and integral limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pms_cfg_regs import pms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain      <= '0;
			cfg_q.i_gain      <= '0;
			cfg_q.d_gain      <= '0;
			cfg_q.integ_limit <= INTEG_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_P_GAIN:      cfg_q.p_gain      <= cfg_wdata;
				REG_I_GAIN:      cfg_q.i_gain      <= cfg_wdata;
				REG_D_GAIN:      cfg_q.d_gain      <= cfg_wdata;
				REG_INTEG_LIMIT: cfg_q.integ_limit <= cfg_wdata[LIM_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/pms_front.sv
// ----------------------------------------------------------------------------
// pms_front
// Error saturation, integral clamping and derivative difference; holds the
// integral sum and previous error state.
// ----------------------------------------------------------------------------
module pms_front import pms_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [SP_W-1:0] setpoint,
	input  logic [MEAS_W-1:0]      measured,
	output logic                   out_valid,
	input  logic                   out_ready,
	output front_t                 out_data
);

	logic signed [ERR_W-1:0] isum_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic                    valid_s1;
	front_t                  data_s1;

	logic signed [RAW_W-1:0] raw;
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] lim;
	logic signed [SUM_W-1:0] neg_lim;
	front_t                  nxt;
	logic                    accept;

	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		raw     = RAW_W'(setpoint) - $signed({2'b00, measured});
		lim     = $signed({2'b00, cfg.integ_limit});
		neg_lim = -lim;

		if (raw > RAW_W'(ERR_MAX)) begin
			nxt.err = ERR_MAX;
		end else if (raw < RAW_W'(ERR_MIN)) begin
			nxt.err = ERR_MIN;
		end else begin
			nxt.err = raw[ERR_W-1:0];
		end

		sum = SUM_W'(isum_q) + SUM_W'(nxt.err);
		if (sum > lim) begin
			nxt.isum  = lim[ERR_W-1:0];
			nxt.clamp = 1'b1;
		end else if (sum < neg_lim) begin
			nxt.isum  = neg_lim[ERR_W-1:0];
			nxt.clamp = 1'b1;
		end else begin
			nxt.isum  = sum[ERR_W-1:0];
			nxt.clamp = 1'b0;
		end

		nxt.diff = DIFF_W'(prev_err_q) - DIFF_W'(nxt.err);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q     <= '0;
			prev_err_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				isum_q     <= nxt.isum;
				prev_err_q <= nxt.err;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### rtl/pms_mult.sv
// ----------------------------------------------------------------------------
// pms_mult
// Proportional, integral and derivative products, one stage.
// ----------------------------------------------------------------------------
module pms_mult import pms_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  front_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output prod_t  out_data
);

	logic  valid_s2;
	prod_t data_s2;
	prod_t nxt;

	assign in_ready = !valid_s2 || out_ready;

	always_comb begin
		nxt.pterm = cfg.p_gain * in_data.err;
		// While clamped, the integral term is the limit itself, not a product.
		if (in_data.clamp) begin
			nxt.iterm = PROD_W'(in_data.isum);
		end else begin
			nxt.iterm = cfg.i_gain * in_data.isum;
		end
		nxt.dterm = cfg.d_gain * in_data.diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

### rtl/pms_scale.sv
// ----------------------------------------------------------------------------
// pms_scale
// Sums the three terms, divides by the scale factor toward zero and clamps
// the quotient to the drive range; holds the result register.
// ----------------------------------------------------------------------------
module pms_scale import pms_pkg::*; #(
	parameter int SCALE_DIV = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  prod_t              in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DRIVE_W-1:0] drive
);

	localparam longint FULL_SCALE = longint'(SCALE_DIV) << DRIVE_W;
	localparam int     NUM_W      = $clog2(FULL_SCALE);
	localparam logic signed [TOT_W-1:0] TOT_FULL = TOT_W'(FULL_SCALE);
	localparam int     DIV_SH     = NUM_W + $clog2(SCALE_DIV);
	localparam longint RECIP      = ((longint'(1) << DIV_SH) + longint'(SCALE_DIV) - 1) /
		longint'(SCALE_DIV);
	localparam int     RECIP_W    = $clog2(RECIP + 1);
	localparam int     QPROD_W    = NUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

	logic               valid_s3;
	logic               zero_s3;
	logic               full_s3;
	logic [NUM_W-1:0]   num_s3;
	logic               valid_q;
	logic [DRIVE_W-1:0] drive_q;

	logic signed [TOT_W-1:0] total;
	logic                    ready_s3;
	logic [QPROD_W-1:0]      qprod;
	logic [DRIVE_W-1:0]      quot;
	logic [DRIVE_W-1:0]      drive_d;

	assign ready_s3 = !valid_q || out_ready;
	assign in_ready = !valid_s3 || ready_s3;

	assign total = TOT_W'(in_data.pterm) + TOT_W'(in_data.iterm) + TOT_W'(in_data.dterm);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s3 <= in_valid;
			end
			if (ready_s3) begin
				valid_q <= valid_s3;
			end
		end
	end

	// Negative totals give a quotient of zero or below; totals of at least
	// 256 times the divisor give a quotient above the drive range.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			zero_s3 <= total < 0;
			full_s3 <= total >= TOT_FULL;
			num_s3  <= total[NUM_W-1:0];
		end
	end

	// A value below 256 times the divisor is divided by multiplying with the
	// reciprocal rounded up. The shift is wide enough that the rounding error
	// never reaches the next quotient step, so the quotient is exact.
	always_comb begin
		qprod = QPROD_W'(num_s3) * QPROD_W'(RECIP_K);
		quot  = qprod[DIV_SH +: DRIVE_W];
		if (zero_s3) begin
			drive_d = DRIVE_MIN;
		end else if (full_s3) begin
			drive_d = DRIVE_MAX;
		end else begin
			drive_d = quot;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s3) begin
			drive_q <= drive_d;
		end
	end

	assign out_valid = valid_q;
	assign drive     = drive_q;

endmodule

### rtl/pid_motor_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_motor_speed_controller
// Each accepted sample passes the front, product, scale and result registers in that order.
// Throughput: one sample per cycle through a four-register pipeline, unless the result channel stalls it.
// Reset clears the integral sum, the previous error and all valid bits;
// gains reset to zero and the integral limit to 32767.
// ----------------------------------------------------------------------------
module pid_motor_speed_controller import pms_pkg::*; #(
	parameter int SCALE_DIV = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	pms_in_if.sink                sample,
	pms_out_if.source             result
);

	cfg_t   cfg;
	logic   front_valid;
	logic   front_ready;
	front_t front_data;
	logic   mult_valid;
	logic   mult_ready;
	prod_t  mult_data;

	pms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.setpoint  (sample.setpoint),
		.measured  (sample.measured),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	pms_mult u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (mult_valid),
		.out_ready (mult_ready),
		.out_data  (mult_data)
	);

	pms_scale #(
		.SCALE_DIV (SCALE_DIV)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mult_valid),
		.in_ready  (mult_ready),
		.in_data   (mult_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.drive     (result.drive)
	);

endmodule
